// File: hdl/cpf_pkg.sv
// Shared types and constants for the command packet framer.
package cpf_pkg;

    // Fixed bytes of the packet header, and the largest content length.
    localparam logic [7:0] START_HI  = 8'hEF;
    localparam logic [7:0] START_LO  = 8'h01;
    localparam logic [7:0] PACKET_ID = 8'h01;
    localparam logic [7:0] LEN_HI    = 8'h00;
    localparam logic [7:0] MAX_LEN   = 8'd253;

    // Width of the result position counter.
    localparam int POS_W = 4;

    // Positions of the result bytes within one packet.
    localparam logic [POS_W-1:0] POS_START_HI = 4'd0;
    localparam logic [POS_W-1:0] POS_START_LO = 4'd1;
    localparam logic [POS_W-1:0] POS_ADDR_3   = 4'd2;
    localparam logic [POS_W-1:0] POS_ADDR_2   = 4'd3;
    localparam logic [POS_W-1:0] POS_ADDR_1   = 4'd4;
    localparam logic [POS_W-1:0] POS_ADDR_0   = 4'd5;
    localparam logic [POS_W-1:0] POS_ID       = 4'd6;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 4'd7;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 4'd8;
    localparam logic [POS_W-1:0] POS_CONTENT  = 4'd9;
    localparam logic [POS_W-1:0] POS_SUM_HI   = 4'd10;
    localparam logic [POS_W-1:0] POS_SUM_LO   = 4'd11;

    // Everything needed to emit the results of one accepted item.
    typedef struct packed {
        logic [7:0]  content_byte;
        logic [7:0]  plen;
        logic [15:0] csum;
        logic        fin;
    } job_t;

    // Flags that go with one result byte.
    typedef struct packed {
        logic run_last;
        logic packet_end;
    } out_flags_t;

endpackage

// File: hdl/cpf_byte_mux.sv
// Selects the result byte and its flags for the current position of a job.
module cpf_byte_mux
    import cpf_pkg::*;
(
    input  job_t             job,
    input  logic [POS_W-1:0] pos,
    input  logic [31:0]      device_address,
    output logic [7:0]       out_byte,
    output out_flags_t       flags
);

    // Byte selection by position in the packet.
    always_comb
    begin
        unique case (pos)
            POS_START_HI: out_byte = START_HI;
            POS_START_LO: out_byte = START_LO;
            POS_ADDR_3:   out_byte = device_address[31:24];
            POS_ADDR_2:   out_byte = device_address[23:16];
            POS_ADDR_1:   out_byte = device_address[15:8];
            POS_ADDR_0:   out_byte = device_address[7:0];
            POS_ID:       out_byte = PACKET_ID;
            POS_LEN_HI:   out_byte = LEN_HI;
            POS_LEN_LO:   out_byte = job.plen;
            POS_CONTENT:  out_byte = job.content_byte;
            POS_SUM_HI:   out_byte = job.csum[15:8];
            POS_SUM_LO:   out_byte = job.csum[7:0];
            default:      out_byte = 8'h00;
        endcase
    end

    // The job ends on the content byte unless the packet closes with its checksum.
    always_comb
    begin
        flags.run_last   = job.fin ? (pos == POS_SUM_LO) : (pos == POS_CONTENT);
        flags.packet_end = job.fin && (pos == POS_SUM_LO);
    end

endmodule

// File: hdl/command_packet_framer_core.sv
// Top level of the command packet framer: input framing state, job register and output port.
//
// The framer takes one content byte per transfer and sends one byte per cycle on the output
// stream while m_tready is high. The first byte of a packet produces ten output bytes (nine
// header bytes, then the content byte), the last byte of a packet produces three (the content
// byte, then the checksum high and low bytes), a one-byte packet produces twelve, and every
// other content byte one. An item holds the block until its last byte leaves the single output
// byte lane; middle content bytes stream at one per cycle unless m_tready stalls them. A new
// item is taken in the same cycle as the last output byte of the previous one. The address
// register, written via the always-ready cfg channel, should only change between packets.
module command_packet_framer_core
    import cpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel: device_address.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] content_byte, [15:8] content_len
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser    // [0] packet_end
);

    logic [31:0]      device_address_reg;
    logic [7:0]       bytes_remaining_reg;
    logic [7:0]       bytes_remaining_next;
    logic [15:0]      running_sum_reg;
    logic [15:0]      running_sum_next;
    job_t             job_reg;
    job_t             job_next;
    logic             job_valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_start;
    logic [7:0]       in_byte;
    logic [7:0]       in_len;
    logic [7:0]       clen;
    logic [7:0]       rem_base;
    logic [15:0]      sum_base;
    logic [15:0]      sum_new;
    logic [7:0]       rem_new;
    logic             in_xfer;
    logic             out_xfer;
    out_flags_t       flags;

    assign in_byte = s_tdata[7:0];
    assign in_len  = s_tdata[15:8];

    // Handshakes: a new item enters when the job register is empty or finishing.
    assign cfg_ready = 1'b1;
    assign out_xfer  = m_tvalid && m_tready;
    assign s_tready  = !job_valid_reg || (out_xfer && flags.run_last);
    assign in_xfer   = s_tvalid && s_tready;

    // Framing arithmetic for the incoming item.
    always_comb
    begin
        if (in_len == 8'd0)
            clen = 8'd1;
        else if (in_len > MAX_LEN)
            clen = MAX_LEN;
        else
            clen = in_len;

        if (bytes_remaining_reg == 8'd0)
        begin
            rem_base  = clen;
            sum_base  = 16'(PACKET_ID) + 16'(clen) + 16'd2;
            pos_start = POS_START_HI;
        end
        else
        begin
            rem_base  = bytes_remaining_reg;
            sum_base  = running_sum_reg;
            pos_start = POS_CONTENT;
        end

        sum_new = sum_base + 16'(in_byte);
        rem_new = rem_base - 8'd1;

        job_next.content_byte = in_byte;
        job_next.plen         = clen + 8'd2;
        job_next.csum         = sum_new;
        job_next.fin          = (rem_new == 8'd0);

        bytes_remaining_next = rem_new;
        running_sum_next     = job_next.fin ? 16'd0 : sum_new;
    end

    // Address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            device_address_reg <= 32'hFFFF_FFFF;
        else if (cfg_valid && cfg_ready)
            device_address_reg <= cfg_data;
    end

    // Packet state, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= 8'd0;
            running_sum_reg     <= 16'd0;
        end
        else if (in_xfer)
        begin
            bytes_remaining_reg <= bytes_remaining_next;
            running_sum_reg     <= running_sum_next;
        end
    end

    // Job register and result position counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pos_reg       <= POS_START_HI;
        end
        else if (in_xfer)
        begin
            job_valid_reg <= 1'b1;
            pos_reg       <= pos_start;
        end
        else if (out_xfer)
        begin
            if (flags.run_last)
                job_valid_reg <= 1'b0;
            else
                pos_reg <= pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            job_reg <= job_next;
    end

    // Output byte selection.
    cpf_byte_mux u_byte_mux
    (
        .job            (job_reg),
        .pos            (pos_reg),
        .device_address (device_address_reg),
        .out_byte       (m_tdata),
        .flags          (flags)
    );

    assign m_tvalid   = job_valid_reg;
    assign m_tlast    = flags.run_last;
    assign m_tuser[0] = flags.packet_end;

    // Between packets the checksum accumulator is clear.
    a_idle_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_remaining_reg == 8'd0) |-> (running_sum_reg == 16'd0))
        else $error("running sum not cleared between packets");

    // The end of a packet is always the last byte of its item.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("packet end without run last");

    // An item is only taken over a pending job when that job's final byte leaves.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> (m_tready && m_tlast))
        else $error("input accepted over a pending job");

    // An accepted item always presents a result in the next cycle.
    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");

endmodule
